@@ hdl/mrc_pkg.sv @@
package mrc_pkg;

  localparam int CmdW   = 2;
  localparam int SetW   = 6;
  localparam int WayW   = 3;
  localparam int StampW = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_QUERY  = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_ACCESS = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } state_e;

  // Status of the victim search unit towards the controller.
  typedef struct packed {
    logic            done;
    logic [WayW-1:0] way;
  } tree_stat_t;

endpackage

@@ hdl/mrc_if.sv @@
interface mrc_item_if;
  logic                      valid;
  logic                      ready;
  logic [mrc_pkg::CmdW-1:0]  cmd;
  logic [mrc_pkg::SetW-1:0]  set_index;
  logic [mrc_pkg::WayW-1:0]  way;
  logic                      hit;
  logic                      is_write;

  modport source (output valid, cmd, set_index, way, hit, is_write, input ready);
  modport sink   (input valid, cmd, set_index, way, hit, is_write, output ready);
endinterface

interface mrc_result_if;
  logic                      valid;
  logic                      ready;
  logic [mrc_pkg::WayW-1:0]  evict_way;

  modport source (output valid, evict_way, input ready);
  modport sink   (input valid, evict_way, output ready);
endinterface

@@ hdl/mrc_ram.sv @@
module mrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mrc_victim_tree.sv @@
module mrc_victim_tree #(
  parameter int WAYS = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  logic [WAYS-1:0][mrc_pkg::StampW-1:0]        row_i,
  output mrc_pkg::tree_stat_t                         stat_o
);

  localparam int Levels = $clog2(WAYS);
  localparam int P2     = 1 << Levels;
  localparam int CntW   = $clog2(Levels + 1);

  logic [mrc_pkg::StampW-1:0] stamp_q [P2];
  logic [mrc_pkg::StampW-1:0] stamp_d [P2];
  logic [Levels-1:0]          idx_q   [P2];
  logic [Levels-1:0]          idx_d   [P2];
  logic [CntW-1:0]            cnt_q, cnt_d;

  // Each step folds pair (2i, 2i+1) into slot i; the upper way wins only on a
  // strictly larger stamp, so ties resolve to the lowest way. Padding slots
  // hold stamp zero at higher indices and can never win against a real way.
  always_comb begin
    stamp_d = stamp_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      for (int i = 0; i < P2; i++) begin
        stamp_d[i] = '0;
        idx_d[i]   = Levels'(i);
      end
      for (int i = 0; i < WAYS; i++) begin
        stamp_d[i] = row_i[i];
      end
      cnt_d = CntW'(Levels);
    end else if (cnt_q != '0) begin
      for (int i = 0; i < P2 / 2; i++) begin
        if (stamp_q[2*i+1] > stamp_q[2*i]) begin
          stamp_d[i] = stamp_q[2*i+1];
          idx_d[i]   = idx_q[2*i+1];
        end else begin
          stamp_d[i] = stamp_q[2*i];
          idx_d[i]   = idx_q[2*i];
        end
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    idx_q   <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.done = (cnt_q == '0);
  assign stat_o.way  = mrc_pkg::WayW'(idx_q[0]);

endmodule

@@ hdl/mru_cache_replacement_core.sv @@
// Channel   Dir  Payload                                   Beat
// item_i    in   cmd, set_index, way, hit, is_write        valid && ready
// result_o  out  evict_way (victim queries only)           valid && ready
//
// One item is in flight at a time. Fill and access updates read the set row
// from the stamp RAM, then write the modified row back.
// A victim query reads the set row, then runs a pairwise search over it, one
// tree level per cycle.
// After reset a clearing pass zeroes the stamp RAM one row a cycle, while
// item_i is held not ready.
// A result waits in the output register; a query that finishes while that
// register is still full holds until result_o is taken.
module mru_cache_replacement_core #(
  parameter int SETS = 64,
  parameter int WAYS = 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  mrc_item_if.sink      item_i,
  mrc_result_if.source  result_o
);

  localparam int AW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RowW = WAYS * mrc_pkg::StampW;

  typedef logic [WAYS-1:0][mrc_pkg::StampW-1:0] row_t;

  mrc_pkg::state_e            state_q, state_d;
  logic [AW-1:0]              clr_idx_q, clr_idx_d;
  logic [mrc_pkg::StampW-1:0] ctr_q, ctr_d;
  logic                       out_valid_q, out_valid_d;
  logic [mrc_pkg::WayW-1:0]   victim_q, victim_d;

  // Item held while its row is in flight.
  logic                       stamp_q, query_q, oor_q;
  logic [mrc_pkg::WayW-1:0]   way_q;
  logic [AW-1:0]              addr_q;

  logic                       item_acc, set_ok, way_ok, stamp_req;
  logic                       clr_last, out_free, out_load, tree_load;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [RowW-1:0]            mem_wdata, mem_rdata;
  row_t                       rd_row, new_row, tree_row;
  mrc_pkg::tree_stat_t        tree_st;

  assign item_acc = item_i.valid && item_i.ready;
  assign set_ok   = 32'(item_i.set_index) < SETS;
  assign way_ok   = 32'(item_i.way) < WAYS;
  assign clr_last = (clr_idx_q == AW'(SETS - 1));
  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    unique case (mrc_pkg::cmd_e'(item_i.cmd))
      mrc_pkg::CMD_FILL:   stamp_req = 1'b1;
      mrc_pkg::CMD_ACCESS: stamp_req = item_i.hit && !item_i.is_write;
      default:             stamp_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      stamp_q <= stamp_req && set_ok && way_ok;
      query_q <= (item_i.cmd == mrc_pkg::CMD_QUERY);
      oor_q   <= !set_ok;
      way_q   <= item_i.way;
      addr_q  <= AW'(item_i.set_index);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrc_pkg::ST_CLEAR: if (clr_last) state_d = mrc_pkg::ST_IDLE;
      mrc_pkg::ST_IDLE:  if (item_acc) state_d = mrc_pkg::ST_RMW;
      mrc_pkg::ST_RMW:   state_d = query_q ? mrc_pkg::ST_SCAN : mrc_pkg::ST_IDLE;
      mrc_pkg::ST_SCAN:  if (out_load) state_d = mrc_pkg::ST_IDLE;
      default:           state_d = mrc_pkg::ST_IDLE;
    endcase
  end

  assign rd_row = row_t'(mem_rdata);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_row[w] = (32'(way_q) == w) ? ctr_q : rd_row[w];
    end
  end

  // Outputs of the controller.
  always_comb begin
    item_i.ready = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = AW'(item_i.set_index);
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = RowW'(new_row);
    tree_load    = 1'b0;
    out_load     = 1'b0;
    clr_idx_d    = clr_idx_q;
    ctr_d        = ctr_q;
    unique case (state_q)
      mrc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        clr_idx_d = clr_idx_q + AW'(1);
      end
      mrc_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        mem_re       = item_acc;
      end
      mrc_pkg::ST_RMW: begin
        mem_we    = stamp_q;
        tree_load = query_q;
        if (stamp_q) begin
          ctr_d = ctr_q + mrc_pkg::StampW'(1);
        end
      end
      mrc_pkg::ST_SCAN: begin
        out_load = tree_st.done && out_free;
      end
      default: begin
        item_i.ready = 1'b0;
      end
    endcase
  end

  // A set beyond the configured range answers way 0.
  assign tree_row = oor_q ? '0 : rd_row;

  always_comb begin
    out_valid_d = out_valid_q;
    victim_d    = victim_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      victim_d    = tree_st.way;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.evict_way = victim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrc_pkg::ST_CLEAR;
      clr_idx_q   <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    victim_q <= victim_d;
  end

  mrc_ram #(
    .WIDTH (RowW),
    .DEPTH (SETS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mrc_victim_tree #(
    .WAYS (WAYS)
  ) u_victim_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (tree_load),
    .row_i  (tree_row),
    .stat_o (tree_st)
  );

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("stamp RAM read and written in the same cycle");

  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrc_pkg::ST_RMW && stamp_q) |=> (ctr_q == $past(ctr_q) + 64'd1))
    else $error("stamp counter did not advance by one on a stamp write");

  a_ctr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == mrc_pkg::ST_RMW && stamp_q) |=> (ctr_q == $past(ctr_q)))
    else $error("stamp counter moved without a stamp write");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (tree_st.done && state_q == mrc_pkg::ST_SCAN))
    else $error("result loaded before the victim search finished");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrc_pkg::ST_CLEAR && state_d == mrc_pkg::ST_IDLE) |-> clr_last)
    else $error("clearing pass left before the last row");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int CmdW   = mrc_pkg::CmdW;
  localparam int SetW   = mrc_pkg::SetW;
  localparam int WayW   = mrc_pkg::WayW;
  localparam int StampW = mrc_pkg::StampW;

  localparam int SetCount    = 64;
  localparam int WayCount    = 8;
  localparam int RandomItems = 450;
  localparam int CalmItems   = 60;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 16;

  // The command code that the block does not define.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // Shadow of the stamp store and the stamp counter, and the victim ways still owed.
  class mru_scoreboard;
    logic [StampW-1:0] stamps [SetCount][WayCount];
    logic [StampW-1:0] next_stamp;
    logic [WayW-1:0]   victims_due [$];
    int unsigned       mismatches;

    function new();
      foreach (stamps[s, w]) stamps[s][w] = '0;
      next_stamp = '0;
      mismatches = 0;
    endfunction

    function void touch_way(logic [SetW-1:0] set_index, logic [WayW-1:0] way);
      if (set_index < SetCount && way < WayCount) begin
        stamps[set_index][way] = next_stamp;
        next_stamp = next_stamp + 1'b1;
      end
    endfunction

    // Largest stamp wins; a strict comparison leaves ties with the lowest way.
    function logic [WayW-1:0] newest_way(logic [SetW-1:0] set_index);
      logic [StampW-1:0] best;
      logic [WayW-1:0]   best_way;
      best_way = '0;
      if (set_index >= SetCount) return best_way;
      best = stamps[set_index][0];
      for (int i = 1; i < WayCount; i++) begin
        if (stamps[set_index][i] > best) begin
          best = stamps[set_index][i];
          best_way = i[WayW-1:0];
        end
      end
      return best_way;
    endfunction

    function void note_item(logic [CmdW-1:0] cmd, logic [SetW-1:0] set_index,
                            logic [WayW-1:0] way, logic hit, logic is_write);
      case (cmd)
        mrc_pkg::CMD_QUERY: victims_due.push_back(newest_way(set_index));
        mrc_pkg::CMD_FILL: touch_way(set_index, way);
        mrc_pkg::CMD_ACCESS: begin
          if (hit && !is_write) touch_way(set_index, way);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_victim(logic [WayW-1:0] got);
      logic [WayW-1:0] want;
      if (victims_due.size() == 0) begin
        report($sformatf("evict_way %0d arrived with no query waiting", got));
      end else begin
        want = victims_due.pop_front();
        if (got !== want) report($sformatf("evict_way %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   stall_cycles;

  mrc_item_if   item_bus ();
  mrc_result_if result_bus ();
  mru_scoreboard ledger;

  mru_cache_replacement_core #(
    .SETS(SetCount),
    .WAYS(WayCount)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one item and holds it until the beat; valid is lowered only for a gap.
  task put_item(logic [CmdW-1:0] cmd, logic [SetW-1:0] set_index, logic [WayW-1:0] way,
                logic hit, logic is_write);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.cmd       <= cmd;
    item_bus.set_index <= set_index;
    item_bus.way       <= way;
    item_bus.hit       <= hit;
    item_bus.is_write  <= is_write;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
  endtask

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        result_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Results are checked before the item of the same edge is noted, so a query
  // is never matched against its own beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) ledger.check_victim(result_bus.evict_way);
      if (item_bus.valid && item_bus.ready) begin
        ledger.note_item(item_bus.cmd, item_bus.set_index, item_bus.way, item_bus.hit,
                         item_bus.is_write);
      end
    end
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $realtime, StallLimit);
      $display("[mru_cache_replacement_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [CmdW-1:0] cmd_r;
    logic [SetW-1:0] set_r;
    logic [SetW-1:0] hot_base;
    int              pick;

    ledger = new();
    calm = 1'b0;
    stall_cycles = 0;
    rst_ni <= 1'b0;
    item_bus.valid     <= 1'b0;
    item_bus.cmd       <= mrc_pkg::CMD_QUERY;
    item_bus.set_index <= '0;
    item_bus.way       <= '0;
    item_bus.hit       <= 1'b0;
    item_bus.is_write  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Untouched sets answer way 0, whatever the ignored fields hold.
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd7, 1'b1, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd63, 3'd0, 1'b0, 1'b0);
    // The very first fill takes stamp zero, which ties with the untouched ways.
    put_item(mrc_pkg::CMD_FILL, 6'd0, 3'd0, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd0, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_FILL, 6'd0, 3'd7, 1'b1, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd2, 1'b1, 1'b0);
    put_item(mrc_pkg::CMD_ACCESS, 6'd0, 3'd3, 1'b1, 1'b0);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd0, 1'b0, 1'b1);
    // A write hit and both kinds of miss must leave the set alone.
    put_item(mrc_pkg::CMD_ACCESS, 6'd0, 3'd5, 1'b1, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd0, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_ACCESS, 6'd0, 3'd6, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_ACCESS, 6'd0, 3'd4, 1'b0, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd0, 1'b0, 1'b0);
    put_item(CmdUnused, 6'd0, 3'd4, 1'b1, 1'b0);
    put_item(CmdUnused, 6'd63, 3'd7, 1'b0, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd0, 3'd0, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_FILL, 6'd63, 3'd7, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_FILL, 6'd63, 3'd0, 1'b1, 1'b0);
    put_item(mrc_pkg::CMD_QUERY, 6'd63, 3'd5, 1'b0, 1'b0);
    put_item(mrc_pkg::CMD_FILL, 6'd42, 3'd5, 1'b0, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd21, 3'd2, 1'b1, 1'b1);
    put_item(mrc_pkg::CMD_QUERY, 6'd42, 3'd0, 1'b0, 1'b0);

    // Most traffic goes to a handful of sets so that their stamps get churned.
    hot_base = SetW'($urandom_range(0, 60));
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - CalmItems) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd_r = mrc_pkg::CMD_QUERY;
      else if (pick < 60) cmd_r = mrc_pkg::CMD_FILL;
      else if (pick < 95) cmd_r = mrc_pkg::CMD_ACCESS;
      else cmd_r = CmdUnused;
      if ($urandom_range(0, 3) == 0) set_r = SetW'($urandom_range(0, SetCount - 1));
      else set_r = hot_base + SetW'($urandom_range(0, 3));
      put_item(cmd_r, set_r, WayW'($urandom_range(0, WayCount - 1)),
               $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)));
    end
    item_bus.valid <= 1'b0;

    while (ledger.victims_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("[mru_cache_replacement_core] OK");
    end else begin
      $display("[mru_cache_replacement_core] ERROR");
    end
    $finish;
  end

endmodule
